/* src/ed3_pkg.sv */
// Shared constants and helpers for the 3D fixed-point distance unit.
// Used by ed3_isqrt, euclidean_distance_3d_fixed_unit and the testbench; no dependencies.
package ed3_pkg;

    localparam int COORD_W     = 32;                 // 16.16 signed coordinate
    localparam int FRAC_BITS   = 16;
    localparam int AXES        = 3;
    localparam int MAG_W       = COORD_W - FRAC_BITS + 1;  // |delta| up to 32768
    localparam int SQ_W        = 2 * (MAG_W - 1) + 1;      // square up to 2^30
    localparam int SUM_W       = 32;                        // up to 3 * 2^30
    localparam int DIST_W      = SUM_W / 2;
    localparam int ROOT_STEPS  = SUM_W / 2;                 // one root bit per stage
    localparam int REM_W       = DIST_W + 3;                // partial remainder
    localparam int IN_TDATA_W  = 2 * AXES * COORD_W;
    localparam int OUT_TDATA_W = ((DIST_W + 7) / 8) * 8;
    localparam logic [DIST_W-1:0] MAX_DIST = DIST_W'(56755);

    typedef logic [MAG_W-1:0] mag_t;
    typedef logic [SQ_W-1:0]  sq_t;

    // Magnitude of the integer delta (a - b) >>> 16, with 32-bit wrap.
    function automatic mag_t axis_mag(input logic [COORD_W-1:0] a,
                                      input logic [COORD_W-1:0] b);
        logic [COORD_W-1:0]           diff;
        logic [COORD_W-FRAC_BITS-1:0] high;
        mag_t                         mag;
        diff = a - b;
        high = diff[COORD_W-1:FRAC_BITS];
        if (diff[COORD_W-1])
            mag = MAG_W'(0) - {1'b1, high};   // 2^16 - high
        else
            mag = {1'b0, high};
        return mag;
    endfunction

endpackage

/* src/euclidean_distance_3d_fixed_unit.sv */
// Top level of the 3D fixed-point distance unit: skid buffer, delta,
// square and sum stages, then the pipelined root. Depends on ed3_pkg, ed3_isqrt.
//
//  channel  | dir | width | payload (low bit up)
//  ---------+-----+-------+-----------------------------------------------
//  s_axis   | in  | 192   | first_x, first_y, first_z, second_x, second_y, second_z
//  m_axis   | out | 16    | distance
//
// One beat in, one beat out. A new beat may enter every cycle while the skid
// register is empty. There are 19 register stages (delta, square, sum, then
// 16 root stages, one root bit each); m_axis_tvalid is the last stage's valid.
// The pipeline moves as a whole whenever the output register is empty or
// taken; a one-beat skid register on the input keeps s_axis_tready registered.
// Reset (rst_n low, asynchronous) clears only valid bits; no state is kept.
module euclidean_distance_3d_fixed_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // first_x[31:0], first_y, first_z, second_x, second_y, second_z[191:160]
    input  logic [ed3_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // distance[15:0]
    output logic [ed3_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    localparam int CW = ed3_pkg::COORD_W;
    localparam int AX = ed3_pkg::AXES;

    logic advance;          // whole pipeline steps this cycle
    logic accept;

    // input skid
    logic                            skid_valid_reg;
    logic                            skid_valid_next;
    logic [ed3_pkg::IN_TDATA_W-1:0]  skid_data_reg;
    logic                            feed_valid;
    logic [ed3_pkg::IN_TDATA_W-1:0]  feed_data;

    // stage 1: axis magnitudes
    logic              s1_valid_reg;
    ed3_pkg::mag_t     s1_mag_reg [AX];
    // stage 2: squares
    logic              s2_valid_reg;
    ed3_pkg::sq_t      s2_sq_reg  [AX];
    // stage 3: sum of squares
    logic                       s3_valid_reg;
    logic [ed3_pkg::SUM_W-1:0]  s3_sum_reg;

    logic                        root_valid;
    logic [ed3_pkg::DIST_W-1:0]  root;

    assign advance       = !root_valid || m_axis_tready;
    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign feed_valid = skid_valid_reg || s_axis_tvalid;
    assign feed_data  = skid_valid_reg ? skid_data_reg : s_axis_tdata;

    // skid fills only when a beat lands while the pipeline is held
    always_comb
    begin
        skid_valid_next = skid_valid_reg;
        if (advance)
            skid_valid_next = 1'b0;
        else if (accept)
            skid_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
            if (advance)
            begin
                s1_valid_reg <= feed_valid;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!advance && accept)
            skid_data_reg <= s_axis_tdata;
        if (advance)
        begin
            for (int i = 0; i < AX; i++)
            begin
                // first point in lanes 0..2, second point in lanes 3..5
                s1_mag_reg[i] <= ed3_pkg::axis_mag(feed_data[i*CW +: CW],
                                                   feed_data[(i+AX)*CW +: CW]);
                s2_sq_reg[i]  <= ed3_pkg::SQ_W'(s1_mag_reg[i])
                               * ed3_pkg::SQ_W'(s1_mag_reg[i]);
            end
            s3_sum_reg <= ed3_pkg::SUM_W'(s2_sq_reg[0])
                        + ed3_pkg::SUM_W'(s2_sq_reg[1])
                        + ed3_pkg::SUM_W'(s2_sq_reg[2]);
        end
    end

    ed3_isqrt u_isqrt
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_valid    (s3_valid_reg),
        .in_radicand (s3_sum_reg),
        .out_valid   (root_valid),
        .out_root    (root)
    );

    assign m_axis_tvalid = root_valid;
    assign m_axis_tdata  = ed3_pkg::OUT_TDATA_W'(root);

    // skid drains into the pipeline on the first step
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && advance |=> !skid_valid_reg)
        else $error("skid beat not drained on advance");

    // a beat taken while held must be parked in the skid
    a_skid_parks: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !advance |=> skid_valid_reg)
        else $error("accepted beat lost while stalled");

    // stage 1 only sees a beat when one was offered or parked
    a_s1_source: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !skid_valid_reg && !s_axis_tvalid |=> !s1_valid_reg)
        else $error("stage 1 valid without a source beat");

    // three magnitudes of at most 2^15 cannot give a root above the bound
    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> root <= ed3_pkg::MAX_DIST)
        else $error("distance out of range");

endmodule

/* src/ed3_isqrt.sv */
// Pipelined floor square root of a 32-bit radicand, one root bit per stage.
// Depends on ed3_pkg for widths.
module ed3_isqrt
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        in_valid,
    input  logic [ed3_pkg::SUM_W-1:0]   in_radicand,
    output logic                        out_valid,
    output logic [ed3_pkg::DIST_W-1:0]  out_root
);

    localparam int N = ed3_pkg::ROOT_STEPS;

    logic                        valid_reg [N];
    logic [ed3_pkg::SUM_W-1:0]   rad_reg   [N];
    logic [ed3_pkg::REM_W-1:0]   rem_reg   [N];
    logic [ed3_pkg::DIST_W-1:0]  root_reg  [N];

    for (genvar g = 0; g < N; g++)
    begin : g_step
        logic                        cur_valid;
        logic [ed3_pkg::SUM_W-1:0]   cur_rad;
        logic [ed3_pkg::REM_W-1:0]   cur_rem;
        logic [ed3_pkg::DIST_W-1:0]  cur_root;
        logic [ed3_pkg::REM_W-1:0]   rem_sh;
        logic [ed3_pkg::REM_W-1:0]   trial;
        logic                        fits;

        if (g == 0)
        begin : g_first
            assign cur_valid = in_valid;
            assign cur_rad   = in_radicand;
            assign cur_rem   = '0;
            assign cur_root  = '0;
        end
        else
        begin : g_rest
            assign cur_valid = valid_reg[g-1];
            assign cur_rad   = rad_reg[g-1];
            assign cur_rem   = rem_reg[g-1];
            assign cur_root  = root_reg[g-1];
        end

        // bring down the next two radicand bits, try root*4+1
        assign rem_sh = {cur_rem[ed3_pkg::REM_W-3:0],
                         cur_rad[ed3_pkg::SUM_W-1:ed3_pkg::SUM_W-2]};
        assign trial  = {1'b0, cur_root, 2'b01};
        assign fits   = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else if (advance)
            begin
                valid_reg[g] <= cur_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rad_reg[g]  <= {cur_rad[ed3_pkg::SUM_W-3:0], 2'b00};
                rem_reg[g]  <= fits ? (rem_sh - trial) : rem_sh;
                root_reg[g] <= {cur_root[ed3_pkg::DIST_W-2:0], fits};
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_root  = root_reg[N-1];

endmodule

/* tb/sv/ed3_distance_checker.sv */
// Scoreboard for the 3D fixed-point distance unit: predicts each distance on s_axis
// beats and compares m_axis beats in order. Depends on ed3_pkg only.
`timescale 1ns / 1ps

module ed3_distance_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [ed3_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [ed3_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output int                                errors,
    output int                                outstanding
);

    // tdata layout, first_x in the low word
    typedef struct packed {
        logic [ed3_pkg::COORD_W-1:0] second_z;
        logic [ed3_pkg::COORD_W-1:0] second_y;
        logic [ed3_pkg::COORD_W-1:0] second_x;
        logic [ed3_pkg::COORD_W-1:0] first_z;
        logic [ed3_pkg::COORD_W-1:0] first_y;
        logic [ed3_pkg::COORD_W-1:0] first_x;
    } point_pair_t;

    logic [ed3_pkg::DIST_W-1:0] expected_distance_q[$];
    logic [ed3_pkg::DIST_W-1:0] want;
    logic [ed3_pkg::DIST_W-1:0] got;

    // |(a - b) >>> 16| with 32-bit wrap on the difference
    function automatic logic [16:0] delta_magnitude(
        input logic [ed3_pkg::COORD_W-1:0] a,
        input logic [ed3_pkg::COORD_W-1:0] b);
        logic [ed3_pkg::COORD_W-1:0] diff;
        logic signed [16:0] whole;
        diff  = a - b;
        whole = {diff[ed3_pkg::COORD_W-1], diff[ed3_pkg::COORD_W-1:ed3_pkg::FRAC_BITS]};
        if (whole < 0)
            whole = -whole;
        return whole;
    endfunction

    // floor root, settled one bit at a time from the top
    function automatic logic [ed3_pkg::DIST_W-1:0] floor_root(
        input logic [ed3_pkg::SUM_W-1:0] value);
        logic [31:0] root;
        logic [31:0] trial;
        root = '0;
        for (int b = ed3_pkg::DIST_W - 1; b >= 0; b--)
        begin
            trial = root | (32'd1 << b);
            if (trial * trial <= value)
                root = trial;
        end
        return root[ed3_pkg::DIST_W-1:0];
    endfunction

    function automatic logic [ed3_pkg::DIST_W-1:0] predict_distance(input point_pair_t p);
        logic [31:0]               mx;
        logic [31:0]               my;
        logic [31:0]               mz;
        logic [ed3_pkg::SUM_W-1:0] sum_sq;
        mx     = 32'(delta_magnitude(p.first_x, p.second_x));
        my     = 32'(delta_magnitude(p.first_y, p.second_y));
        mz     = 32'(delta_magnitude(p.first_z, p.second_z));
        sum_sq = mx * mx + my * my + mz * mz;   // at most 3 * 2^30, no wrap
        return floor_root(sum_sq);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            errors      <= 0;
            outstanding <= 0;
            expected_distance_q.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_distance_q.push_back(predict_distance(point_pair_t'(s_axis_tdata)));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[ed3_pkg::DIST_W-1:0];
                if (expected_distance_q.size() == 0)
                begin
                    $display("%0t: unexpected distance beat, expected none, actual %0d",
                             $time, got);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_distance_q.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: distance mismatch, expected %0d, actual %0d",
                                 $time, want, got);
                        errors <= errors + 1;
                    end
                end
            end
            outstanding <= expected_distance_q.size();
        end
    end

endmodule

/* tb/sv/tb_euclidean_distance_3d_fixed_unit.sv */
// Top of the distance unit testbench: clock, reset, s_axis stimulus, m_axis backpressure
// and the verdict. Depends on ed3_pkg, euclidean_distance_3d_fixed_unit, ed3_distance_checker.
`timescale 1ns / 1ps

module tb_euclidean_distance_3d_fixed_unit;

    localparam int RUN_LIMIT   = 400000;  // cycles before the watchdog ends the run
    localparam int HOLD_CYCLES = 80;      // long m_axis hold-off, deeper than the pipe
    localparam int TAIL_CYCLES = 40;      // settle time after the last distance beat

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [ed3_pkg::IN_TDATA_W-1:0]    s_axis_tdata = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [ed3_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;

    int errors;
    int outstanding;
    int cycle_count = 0;

    // Idle controls: send_gaps for the sender, the rest shared with the receiver process
    bit send_gaps  = 1'b0;
    bit recv_stall = 1'b0;
    int hold_left  = 0;
    int stall_left = 0;

    euclidean_distance_3d_fixed_unit uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ed3_distance_checker scoreboard
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .errors        (errors),
        .outstanding   (outstanding)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // m_axis side. A requested hold-off wins over random stall bursts; both are
    // counted down here so the sender keeps pushing while tready is low.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready = 1'b0;
                hold_left     = hold_left - 1;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready = 1'b0;
                stall_left    = stall_left - 1;
            end
            else if (recv_stall && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready = 1'b0;
                stall_left    = $urandom_range(0, 7);   // random burst length, counted down above
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    // tdata layout: first_x lowest, second_z highest
    function automatic logic [ed3_pkg::IN_TDATA_W-1:0] point_beat(
        input logic [31:0] fx, input logic [31:0] fy, input logic [31:0] fz,
        input logic [31:0] sx, input logic [31:0] sy, input logic [31:0] sz);
        return {sz, sy, sx, fz, fy, fx};
    endfunction

    // One coordinate from the boundary set: the signed extremes, zero, -epsilon,
    // +/- one whole unit
    function automatic logic [31:0] edge_coord();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'h0001_0000;
            default: return 32'hFFFF_0000;
        endcase
    endfunction

    // Second coordinate near the first: integer delta within +/-4096 and a random
    // fraction, which makes the shift floor land on both sides of zero
    function automatic logic [31:0] near_coord(input logic [31:0] base);
        return base + ((32'($urandom_range(0, 8191)) - 32'd4096) << 16)
                    + 32'($urandom_range(0, 65535));
    endfunction

    function automatic logic [ed3_pkg::IN_TDATA_W-1:0] random_point_pair();
        logic [31:0] fx;
        logic [31:0] fy;
        logic [31:0] fz;
        fx = $urandom();
        fy = $urandom();
        fz = $urandom();
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
                return point_beat(fx, fy, fz, $urandom(), $urandom(), $urandom());
            4, 5, 6, 7:
                return point_beat(fx, fy, fz, near_coord(fx), near_coord(fy), near_coord(fz));
            8:
                return point_beat(edge_coord(), edge_coord(), edge_coord(),
                                  edge_coord(), edge_coord(), edge_coord());
            default:
                // same integer parts, fractions only differ: delta is 0 or -1
                return point_beat(fx, fy, fz,
                                  {fx[31:16], 16'($urandom())},
                                  {fy[31:16], 16'($urandom())},
                                  {fz[31:16], 16'($urandom())});
        endcase
    endfunction

    // Offer one beat on s_axis and hold it until accepted. tvalid stays high on
    // return so back-to-back beats need no second write in the same step.
    task automatic send_point_pair(input logic [ed3_pkg::IN_TDATA_W-1:0] beat);
        if (send_gaps && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = beat;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Sender pause: drop tvalid and wait for the scoreboard to empty
    task automatic wait_all_distances();
        s_axis_tvalid = 1'b0;
        @(negedge clk);
        while (outstanding != 0 || m_axis_tvalid)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: all-zero, signed extremes and 32-bit wrap, fraction-only
        // deltas, exact squares and just-below-square sums
        send_point_pair(point_beat(0, 0, 0, 0, 0, 0));
        send_point_pair(point_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_point_pair(point_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        // largest magnitude on every axis: 3 * 2^30, root 56755
        send_point_pair(point_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0));
        send_point_pair(point_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));
        send_point_pair(point_beat(0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_point_pair(point_beat(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        send_point_pair(point_beat(0, 0, 0, 1, 1, 1));        // tiny negative floors to -1
        send_point_pair(point_beat(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 0, 0, 0));
        send_point_pair(point_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0));
        send_point_pair(point_beat(32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0));
        send_point_pair(point_beat(0, 0, 0, 32'h0003_0000, 32'h0004_0000, 0));
        send_point_pair(point_beat(32'h0002_0000, 32'h0003_0000, 32'h0006_0000, 0, 0, 0));
        send_point_pair(point_beat(32'h8000_0000, 0, 0, 0, 0, 0));
        send_point_pair(point_beat(0, 32'h8000_0000, 0, 0, 0, 0));
        send_point_pair(point_beat(0, 0, 32'h8000_0000, 0, 0, 0));
        send_point_pair(point_beat(32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 0, 0, 0));
        send_point_pair(point_beat(32'h0004_0000, 32'h0004_0000, 32'h0006_0000, 0, 0, 0));
        send_point_pair(point_beat(32'h0004_0000, 32'h0004_0000, 32'h0007_0000, 0, 0, 0));
        send_point_pair(point_beat(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                   32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
        wait_all_distances();

        // Random with idle bursts on both sides
        send_gaps  = 1'b1;
        recv_stall = 1'b1;
        for (int n = 0; n < 200; n++)
            send_point_pair(random_point_pair());

        // Long receiver hold-off while the sender streams without gaps: the
        // pipe and skid buffer fill and s_axis_tready must drop
        send_gaps = 1'b0;
        hold_left = HOLD_CYCLES;
        for (int n = 0; n < 40; n++)
            send_point_pair(random_point_pair());
        send_gaps = 1'b1;

        for (int n = 0; n < 200; n++)
            send_point_pair(random_point_pair());
        wait_all_distances();

        for (int n = 0; n < 350; n++)
            send_point_pair(random_point_pair());

        // Last stretch at full rate, no idling anywhere
        send_gaps  = 1'b0;
        recv_stall = 1'b0;
        for (int n = 0; n < 150; n++)
            send_point_pair(random_point_pair());

        wait_all_distances();
        repeat (TAIL_CYCLES) @(negedge clk);

        if (errors == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
